// ----- hw/rtl/anhl_pkg.sv -----
package anhl_pkg;

	localparam int TableDepth = 4096;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam logic [31:0] CrcPoly = 32'h04C11DB7;
	localparam int TopShift = 24;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_BYTE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// Work handed from the front part to the search engine.
	typedef struct packed {
		logic is_write;
		logic [IdxW-1:0] idx;
		logic [31:0] hash;
		logic [1:0] flags;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} srch_state_t;

	// MSB-first CRC table entry for a top byte.
	function automatic logic [31:0] crc_entry(input logic [7:0] top);
		logic [31:0] v;
		v = {top, 24'd0};
		for (int k = 0; k < 8; k++) begin
			v = v[31] ? ((v << 1) ^ CrcPoly) : (v << 1);
		end
		return v;
	endfunction

endpackage

// ----- hw/rtl/archive_name_hash_lookup.sv -----
// Throughput: name bytes and writes enter one per cycle while the two-entry queue is not full;
// searches occupy the table for about log2(entry_count) reads, and queued writes wait meanwhile.
// Reset clears the hash state, count and queue; the table stays undefined until written.
module archive_name_hash_lookup (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [12:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] cmd,
	input  logic [11:0] entry_index,
	input  logic [31:0] entry_hash,
	input  logic entry_is_file,
	input  logic entry_is_deleted,
	input  logic [7:0] name_byte,
	input  logic name_last,
	input  logic [31:0] lookup_hash,
	output logic out_valid,
	input  logic out_stall,
	output logic found,
	output logic [11:0] match_index,
	output logic [31:0] name_hash
);
	import anhl_pkg::*;

	logic [12:0] count_q;
	logic f_valid, f_stall, q_valid, q_take;
	job_t f_job, q_job;

	// Entry count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cfg_we) count_q <= cfg_wdata;
	end

	anhl_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .cmd, .entry_index, .entry_hash,
		.entry_is_file, .entry_is_deleted, .name_byte, .name_last, .lookup_hash,
		.job_valid(f_valid), .job_stall(f_stall), .job(f_job)
	);

	anhl_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
		.rd_valid(q_valid), .rd_take(q_take), .rd_job(q_job)
	);

	anhl_search u_search (
		.clk, .arst_n, .count(count_q), .job_valid(q_valid), .job_take(q_take),
		.job(q_job), .out_valid, .out_stall, .found, .match_index, .name_hash
	);

endmodule

// ----- hw/rtl/anhl_front.sv -----
module anhl_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] cmd,
	input  logic [anhl_pkg::IdxW-1:0] entry_index,
	input  logic [31:0] entry_hash,
	input  logic entry_is_file,
	input  logic entry_is_deleted,
	input  logic [7:0] name_byte,
	input  logic name_last,
	input  logic [31:0] lookup_hash,
	output logic job_valid,
	input  logic job_stall,
	output anhl_pkg::job_t job
);
	import anhl_pkg::*;

	logic [31:0] acc_q;
	logic [2:0] seen_q;
	logic [7:0] lc;
	logic [31:0] acc_n;
	logic acc_full;
	logic take;

	assign in_stall = job_stall;
	assign take = in_valid && !job_stall;

	// Lowercase ASCII letters before hashing.
	assign lc = (name_byte >= 8'h41 && name_byte <= 8'h5A) ? name_byte + 8'd32 : name_byte;

	// Next hash value after this byte.
	always_comb begin
		acc_full = 1'b0;
		if (seen_q < 3'd4) begin
			acc_n = acc_q | ({24'd0, lc} << (TopShift - 8 * 32'(seen_q)));
			if (seen_q == 3'd3) begin
				acc_n = ~acc_n;
				acc_full = 1'b1;
			end
		end else begin
			acc_n = crc_entry(acc_q[31:24]) ^ {acc_q[23:0], lc};
			acc_full = 1'b1;
		end
	end

	// Accumulator update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			seen_q <= '0;
		end else if (take && cmd == CMD_BYTE) begin
			if (name_last) begin
				acc_q <= '0;
				seen_q <= '0;
			end else begin
				acc_q <= acc_n;
				if (seen_q < 3'd4) seen_q <= seen_q + 3'd1;
			end
		end
	end

	// Classify the request into a job for the back part.
	always_comb begin
		job_valid = 1'b0;
		job.is_write = 1'b0;
		job.idx = entry_index;
		job.hash = lookup_hash;
		job.flags = {entry_is_deleted, entry_is_file};
		unique case (cmd_t'(cmd))
			CMD_WRITE: begin
				job_valid = in_valid;
				job.is_write = 1'b1;
				job.hash = entry_hash;
			end
			CMD_BYTE: begin
				job_valid = in_valid && name_last;
				job.hash = acc_full ? ~acc_n : acc_n;
			end
			CMD_LOOKUP: job_valid = in_valid;
			default: job_valid = 1'b0;
		endcase
	end

endmodule

// ----- hw/rtl/anhl_queue.sv -----
module anhl_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_stall,
	input  anhl_pkg::job_t wr_job,
	output logic rd_valid,
	input  logic rd_take,
	output anhl_pkg::job_t rd_job
);
	import anhl_pkg::*;

	job_t mem_q [2];
	logic [1:0] wp_q, rp_q;
	logic full, empty;

	assign full = (wp_q[1] != rp_q[1]) && (wp_q[0] == rp_q[0]);
	assign empty = wp_q == rp_q;
	assign wr_stall = full;
	assign rd_valid = !empty;
	assign rd_job = mem_q[rp_q[0]];

	// Two-entry queue storage.
	always_ff @(posedge clk) begin
		if (wr_valid && !full) mem_q[wp_q[0]] <= wr_job;
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_valid && !full) wp_q <= wp_q + 2'd1;
			if (rd_take && !empty) rp_q <= rp_q + 2'd1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> !empty) else $error("queue lost entries");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_stall |-> rd_valid) else $error("stall while empty");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid && !rd_take) |=> rd_valid) else $error("entry vanished");

endmodule

// ----- hw/rtl/anhl_search.sv -----
module anhl_search (
	input  logic clk,
	input  logic arst_n,
	input  logic [anhl_pkg::CntW-1:0] count,
	input  logic job_valid,
	output logic job_take,
	input  anhl_pkg::job_t job,
	output logic out_valid,
	input  logic out_stall,
	output logic found,
	output logic [anhl_pkg::IdxW-1:0] match_index,
	output logic [31:0] name_hash
);
	import anhl_pkg::*;

	srch_state_t state_q, state_n;
	logic [31:0] hash_mem [TableDepth];
	logic [1:0] flag_mem [TableDepth];
	logic [31:0] rd_hash_q;
	logic [1:0] rd_flag_q;
	logic [CntW-1:0] lo_q, hi_q, mid;
	logic [31:0] key_q;
	logic found_q;
	logic [IdxW-1:0] idx_q;
	logic [CntW-1:0] hi0;
	logic hit, last;

	assign hi0 = (count > CntW'(TableDepth)) ? CntW'(TableDepth) : count;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign hit = key_q == rd_hash_q && rd_flag_q == 2'b01;

	// Table memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid && job.is_write) begin
			hash_mem[job.idx] <= job.hash;
			flag_mem[job.idx] <= job.flags;
		end
		rd_hash_q <= hash_mem[mid[IdxW-1:0]];
		rd_flag_q <= flag_mem[mid[IdxW-1:0]];
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		last = 1'b0;
		unique case (state_q)
			ST_IDLE: if (job_valid && !job.is_write) state_n = (hi0 == '0) ? ST_DONE : ST_READ;
			ST_READ: state_n = ST_CHECK;
			ST_CHECK: begin
				last = hit || (hi_q == lo_q + 1'b1) ||
					((key_q < rd_hash_q) ? (mid == lo_q) : (mid == hi_q));
				state_n = last ? ST_DONE : ST_READ;
			end
			ST_DONE: if (!out_stall) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		job_take = state_q == ST_IDLE && job_valid;
		out_valid = state_q == ST_DONE;
		found = found_q;
		match_index = idx_q;
		name_hash = key_q;
	end

	// Search registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lo_q <= '0;
			hi_q <= '0;
			key_q <= '0;
			found_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_IDLE && job_valid && !job.is_write) begin
				lo_q <= '0;
				hi_q <= hi0;
				key_q <= job.hash;
				found_q <= 1'b0;
				idx_q <= '0;
			end else if (state_q == ST_CHECK) begin
				if (hit) begin
					found_q <= 1'b1;
					idx_q <= mid[IdxW-1:0];
				end else if (key_q < rd_hash_q) hi_q <= mid;
				else lo_q <= mid;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(name_hash)) else $error("result lost");
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> match_index == '0) else $error("index not zero");
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> lo_q < hi_q) else $error("bad bounds");

endmodule

// ----- verif/archive_name_hash_lookup_test.sv -----
`timescale 1ns / 1ps

module archive_name_hash_lookup_test;
	import anhl_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 40;
	localparam int Phases = 10;
	localparam logic [12:0] PhaseCounts [Phases] = '{13'd1, 13'd2, 13'd8, 13'd3, 13'd6,
		13'd17, 13'd0, 13'd40, 13'd12, 13'd9};
	localparam int PhaseSizes [Phases] = '{1, 2, 8, 3, 8, 17, 5, 40, 12, 9};

	typedef struct {
		cmd_t op;
		logic [11:0] idx;
		logic [31:0] ehash;
		logic is_file;
		logic is_del;
		logic [7:0] nbyte;
		logic last;
		logic [31:0] key;
	} request_t;

	typedef struct {
		logic hit;
		logic [11:0] slot;
		logic [31:0] hash;
	} answer_t;

	typedef logic [7:0] name_t[$];

	// Tracks the block's table, count and name hash and holds the answers still owed.
	class lookup_scoreboard;
		logic [31:0] slot_hash[TableDepth];
		logic [1:0] slot_flags[TableDepth];
		logic [12:0] count;
		logic [31:0] acc;
		int unsigned seen;
		answer_t owed[$];
		int errors;

		function new();
			count = 0;
			acc = 0;
			seen = 0;
			errors = 0;
		endfunction

		// Lowercases one byte and folds it into a running name hash.
		static function void fold_byte(inout logic [31:0] a, inout int unsigned n,
				input logic [7:0] b);
			logic [7:0] c;
			logic [31:0] t;
			c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
			if (n < 4) begin
				a = a | ({24'd0, c} << (24 - 8 * n));
				n++;
				if (n == 4)
					a = ~a;
			end else begin
				t = {a[31:24], 24'd0};
				repeat (8) t = {t[30:0], 1'b0} ^ (t[31] ? CrcPoly : 32'd0);
				a = t ^ {a[23:0], c};
			end
		endfunction

		static function logic [31:0] key_of(name_t nm);
			logic [31:0] a;
			int unsigned n;
			a = 0;
			n = 0;
			foreach (nm[i]) fold_byte(a, n, nm[i]);
			return (n >= 4) ? ~a : a;
		endfunction

		// Halving search over the loaded slots, live undeleted files only.
		function answer_t search(logic [31:0] key);
			answer_t r;
			int unsigned lo, hi, mid;
			r.hit = 0;
			r.slot = 0;
			r.hash = key;
			lo = 0;
			hi = (count > TableDepth) ? TableDepth : count;
			if (hi == 0)
				return r;
			forever begin
				mid = lo + (hi - lo) / 2;
				if (key == slot_hash[mid] && slot_flags[mid] == 2'b01) begin
					r.hit = 1;
					r.slot = mid[11:0];
					return r;
				end
				if (hi == lo + 1)
					return r;
				if (key < slot_hash[mid])
					hi = mid;
				else
					lo = mid;
				if (hi == lo)
					return r;
			end
		endfunction

		function void note(request_t q);
			logic [31:0] key;
			case (q.op)
				CMD_WRITE: begin
					slot_hash[q.idx] = q.ehash;
					slot_flags[q.idx] = {q.is_del, q.is_file};
				end
				CMD_BYTE: begin
					fold_byte(acc, seen, q.nbyte);
					if (q.last) begin
						key = (seen >= 4) ? ~acc : acc;
						acc = 0;
						seen = 0;
						owed = {owed, search(key)};
					end
				end
				CMD_LOOKUP: owed = {owed, search(q.key)};
				default: ;
			endcase
		endfunction

		function void check(logic f, logic [11:0] m, logic [31:0] h);
			answer_t e;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: found %0d index %0d hash %h", f, m, h);
				return;
			end
			e = owed.pop_front();
			if (f !== e.hit || m !== e.slot || h !== e.hash) begin
				errors++;
				if (errors <= 10)
					$display("result differs: expected %0d/%0d/%h, got %0d/%0d/%h",
						e.hit, e.slot, e.hash, f, m, h);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [12:0] cfg_wdata = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] cmd = CMD_NONE;
	logic [11:0] entry_index = 0;
	logic [31:0] entry_hash = 0;
	logic entry_is_file = 0;
	logic entry_is_deleted = 0;
	logic [7:0] name_byte = 0;
	logic name_last = 0;
	logic [31:0] lookup_hash = 0;
	logic out_valid;
	logic out_stall = 0;
	logic found;
	logic [11:0] match_index;
	logic [31:0] name_hash;

	lookup_scoreboard sb = new();
	bit quiet = 0;
	int cycles = 0;
	name_t names[8];

	archive_name_hash_lookup u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
		.entry_index(entry_index), .entry_hash(entry_hash),
		.entry_is_file(entry_is_file), .entry_is_deleted(entry_is_deleted),
		.name_byte(name_byte), .name_last(name_last), .lookup_hash(lookup_hash),
		.out_valid(out_valid), .out_stall(out_stall), .found(found),
		.match_index(match_index), .name_hash(name_hash)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Cycle counter with a hard stop.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("archive_name_hash_lookup: mismatch");
			$finish;
		end
	end

	// Result side: check accepted results and stall at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check(found, match_index, name_hash);
			out_stall <= !quiet && ($urandom_range(99) < 36);
		end
	end

	function automatic request_t any_request(cmd_t op);
		request_t q;
		q.op = op;
		q.idx = 12'($urandom);
		q.ehash = $urandom;
		q.is_file = 1'($urandom);
		q.is_del = 1'($urandom);
		q.nbyte = 8'($urandom);
		q.last = 1'($urandom);
		q.key = $urandom;
		return q;
	endfunction

	// Presents one request, idling first at random, and returns at its acceptance edge.
	task automatic send(request_t q);
		int gap;
		gap = 0;
		while (!quiet && $urandom_range(99) < 36) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= q.op;
		entry_index <= q.idx;
		entry_hash <= q.ehash;
		entry_is_file <= q.is_file;
		entry_is_deleted <= q.is_del;
		name_byte <= q.nbyte;
		name_last <= q.last;
		lookup_hash <= q.key;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note(q);
	endtask

	task automatic write_slot(int i, logic [31:0] h, logic [1:0] fl);
		request_t q;
		q = any_request(CMD_WRITE);
		q.idx = 12'(i);
		q.ehash = h;
		q.is_file = fl[0];
		q.is_del = fl[1];
		send(q);
	endtask

	task automatic lookup(logic [31:0] key);
		request_t q;
		q = any_request(CMD_LOOKUP);
		q.key = key;
		send(q);
	endtask

	// Streams a name, flipping letter case at random and, when mix is set, interleaving other requests.
	task automatic stream_name(name_t nm, bit mix);
		request_t q;
		foreach (nm[i]) begin
			if (mix && $urandom_range(9) == 0) begin
				q = any_request($urandom_range(1) ? CMD_LOOKUP : CMD_WRITE);
				if (q.op == CMD_LOOKUP && sb.count > 0)
					q.key = sb.slot_hash[$urandom_range(sb.count - 1)];
				send(q);
			end
			q = any_request(CMD_BYTE);
			q.nbyte = nm[i];
			if (q.nbyte >= 8'h61 && q.nbyte <= 8'h7A && $urandom_range(1))
				q.nbyte = q.nbyte - 8'd32;
			q.last = (i == nm.size() - 1);
			send(q);
		end
	endtask

	// Waits until every owed result has come and the block has settled.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_count(logic [12:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 13'($urandom);
		sb.count = v;
	endtask

	function automatic name_t random_name();
		name_t nm;
		int len;
		logic [7:0] b;
		len = $urandom_range(1, 9);
		repeat (len) begin
			case ($urandom_range(5))
				0: b = 8'($urandom);
				1: b = "/";
				2: b = 8'(8'h30 + $urandom_range(9));
				default: b = 8'(8'h61 + $urandom_range(25));
			endcase
			nm = {nm, b};
		end
		return nm;
	endfunction

	// Draws new names, then rewrites the first n slots with a sorted table that holds the first min(n, 8) names.
	task automatic build_table(int n);
		logic [31:0] hs[$];
		logic [1:0] fl;
		foreach (names[j]) names[j] = random_name();
		for (int i = 0; i < n; i++)
			hs = {hs, (i < 8) ? lookup_scoreboard::key_of(names[i]) : $urandom};
		hs.sort();
		foreach (hs[i]) begin
			fl = ($urandom_range(99) < 80) ? 2'b01 : 2'($urandom);
			write_slot(i, hs[i], fl);
		end
	endtask

	task automatic random_burst(int m);
		int i;
		int r;
		i = 0;
		while (i < m) begin
			r = $urandom_range(99);
			if (r < 60) begin
				if ($urandom_range(9) < 7)
					stream_name(names[$urandom_range(7)], 1);
				else
					stream_name(random_name(), 1);
				i += 4;
			end else if (r < 80) begin
				if (sb.count > 0 && $urandom_range(3) != 0)
					lookup(sb.slot_hash[$urandom_range(sb.count - 1)]);
				else
					lookup($urandom);
				i++;
			end else if (r < 93) begin
				send(any_request(CMD_WRITE));
				i++;
			end else begin
				send(any_request(CMD_NONE));
			end
		end
	endtask

	initial begin
		request_t q;
		name_t nm;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part with no archive loaded.
		set_count(13'd0);
		lookup(32'h0);
		lookup(32'hFFFFFFFF);
		nm = '{8'h41};
		stream_name(nm, 0);
		nm = '{8'h41, 8'h42, 8'h43, 8'h5A};
		stream_name(nm, 0);
		nm = '{8'h61, 8'h00, 8'hFF, 8'h2F, 8'h7A, 8'h00};
		stream_name(nm, 0);
		send(any_request(CMD_NONE));
		q = any_request(CMD_BYTE);
		q.nbyte = 8'h62;
		q.last = 0;
		send(q);
		lookup(32'h12345678);
		write_slot(7, 32'hA5A5A5A5, 2'b01);
		q.nbyte = 8'h63;
		q.last = 1;
		send(q);

		// Full count: only the slots on the leftmost and rightmost search paths are
		// loaded, and the keys below never leave those paths.
		write_slot(0, 32'h0, 2'b01);
		for (int s = 1; s < TableDepth; s = s * 2)
			write_slot(s, {s[11:0], 20'($urandom)}, 2'b01);
		for (int s = TableDepth / 2 + TableDepth / 4; s < TableDepth - 1;
				s = s + (TableDepth - s) / 2)
			write_slot(s, {s[11:0], 20'($urandom)}, 2'b01);
		write_slot(TableDepth - 1, 32'hFFFFFFFF, 2'b01);
		set_count(13'd4096);
		lookup(32'h0);
		lookup(32'hFFFFFFFF);
		lookup(sb.slot_hash[2048]);
		lookup(32'h1);
		write_slot(0, 32'h0, 2'b11);
		lookup(32'h0);
		write_slot(TableDepth - 1, 32'hFFFFFFFF, 2'b00);
		lookup(32'hFFFFFFFF);

		// Random phases over several table sizes and counts.
		for (int p = 0; p < Phases; p++) begin
			build_table(PhaseSizes[p]);
			set_count(PhaseCounts[p]);
			quiet = (p == 3);
			random_burst(28);
			if (p == 5)
				settle();
			random_burst(24);
			quiet = 0;
		end

		settle();
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("archive_name_hash_lookup: match");
		else
			$display("archive_name_hash_lookup: mismatch");
		$finish;
	end

endmodule
